### rtl/pwc_pkg.sv
`timescale 1ns / 1ps
// Package for the penalty weight controller: configuration and divider types,
// register index codes, policy codes and shared rounding and clamp functions.
package pwc_pkg;

   localparam int DVND_W         = 64;
   localparam int DVSR_W         = 48;
   localparam int WEIGHT_MIN_DEF = 66;

   localparam logic [2:0] CSR_POLICY      = 3'd0;
   localparam logic [2:0] CSR_WEIGHT_MAX  = 3'd1;
   localparam logic [2:0] CSR_WL_DELTA    = 3'd2;
   localparam logic [2:0] CSR_INTERVAL    = 3'd3;
   localparam logic [2:0] CSR_HORIZON     = 3'd4;
   localparam logic [2:0] CSR_STOP_LEVEL  = 3'd5;
   localparam logic [2:0] CSR_WL_BASE     = 3'd6;
   localparam logic [2:0] CSR_OV_BASE     = 3'd7;

   localparam logic [1:0] POL_STEP_DECAY  = 2'd0;
   localparam logic [1:0] POL_TRAJECTORY  = 2'd1;
   localparam logic [1:0] POL_RATIO       = 2'd2;

   typedef struct packed {
      logic [1:0]  policy;
      logic [31:0] weight_max;
      logic [47:0] wl_delta_ref;
      logic [9:0]  interval;
      logic [19:0] horizon;
      logic [17:0] stop_level;
      logic [47:0] wl_baseline;
      logic [17:0] ov_baseline;
   } pwc_cfg_type;

   typedef struct packed {
      logic              start;
      logic [DVND_W-1:0] dividend;
      logic [DVSR_W-1:0] divisor;
   } pwc_div_req_type;

   typedef struct packed {
      logic              done;
      logic [DVND_W-1:0] quo;
      logic [DVSR_W-1:0] rem;
   } pwc_div_rsp_type;

   function automatic logic signed [47:0] rdiv16(input logic signed [47:0] v);
      logic [47:0] m;
      m = v[47] ? 48'(-v) : 48'(v);
      m = (m + 48'd32768) >> 16;
      return v[47] ? -$signed(m) : $signed(m);
   endfunction

   function automatic logic [31:0] clamp_w(input logic [51:0] v, input logic [31:0] wmin,
                                           input logic [31:0] wmax);
      logic [51:0] t;
      t = (v < 52'(wmin)) ? 52'(wmin) : v;
      if (t > 52'(wmax)) t = 52'(wmax);
      return t[31:0];
   endfunction

endpackage

### rtl/pwc_div.sv
`timescale 1ns / 1ps
// Shared radix-2 restoring divider, one quotient bit per cycle.
// Depends on pwc_pkg for the request and response types.
module pwc_div import pwc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  pwc_div_req_type div_req,
   output pwc_div_rsp_type div_rsp
);
   localparam int CNT_W = $clog2(DVND_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DVSR_W-1:0] rem_ff, rem_in;
   logic [DVND_W-1:0] quo_ff, quo_in;
   logic [DVSR_W-1:0] dvsr_ff, dvsr_in;
   logic [DVSR_W:0]   shifted;
   logic [DVSR_W:0]   diff;
   logic              fits;

   assign shifted = {rem_ff, quo_ff[DVND_W-1]};
   assign fits    = shifted >= {1'b0, dvsr_ff};
   assign diff    = shifted - {1'b0, dvsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvsr_in = dvsr_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dvsr_in = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DVSR_W-1:0] : shifted[DVSR_W-1:0];
         quo_in = {quo_ff[DVND_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DVND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvsr_ff <= dvsr_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quo  = quo_ff;
   assign div_rsp.rem  = rem_ff;

endmodule

### rtl/pwc_core.sv
`timescale 1ns / 1ps
// Sequencer and datapath of the penalty weight controller: policies, Taylor exp
// and weight scaling. Depends on pwc_pkg and drives the shared pwc_div divider.
module pwc_core import pwc_pkg::*; #(
   parameter int WEIGHT_MIN = WEIGHT_MIN_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  pwc_cfg_type     cfg,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic            req_mode,
   input  logic [19:0]     req_step,
   input  logic [47:0]     req_wirelength,
   input  logic [17:0]     req_overflow,
   input  logic [31:0]     req_start_weight,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic [31:0]     rsp_weight,
   output logic            rsp_adjusted,
   output pwc_div_req_type div_req,
   input  pwc_div_rsp_type div_rsp
);
   localparam logic [5:0] S_IDLE   = 6'd0;
   localparam logic [5:0] S_DISP   = 6'd1;
   localparam logic [5:0] S_MODW   = 6'd2;
   localparam logic [5:0] S_SD_Y   = 6'd3;
   localparam logic [5:0] S_SD_Q   = 6'd4;
   localparam logic [5:0] S_SD_QW  = 6'd5;
   localparam logic [5:0] S_SD_E   = 6'd6;
   localparam logic [5:0] S_SD_E2  = 6'd7;
   localparam logic [5:0] S_SD_P   = 6'd8;
   localparam logic [5:0] S_SD_F   = 6'd9;
   localparam logic [5:0] S_R0     = 6'd10;
   localparam logic [5:0] S_R1     = 6'd11;
   localparam logic [5:0] S_R2     = 6'd12;
   localparam logic [5:0] S_R3     = 6'd13;
   localparam logic [5:0] S_T0     = 6'd14;
   localparam logic [5:0] S_TPW    = 6'd15;
   localparam logic [5:0] S_T1     = 6'd16;
   localparam logic [5:0] S_T2     = 6'd17;
   localparam logic [5:0] S_T3     = 6'd18;
   localparam logic [5:0] S_T4     = 6'd19;
   localparam logic [5:0] S_T5     = 6'd20;
   localparam logic [5:0] S_T6     = 6'd21;
   localparam logic [5:0] S_T7     = 6'd22;
   localparam logic [5:0] S_T8     = 6'd23;
   localparam logic [5:0] S_T9     = 6'd24;
   localparam logic [5:0] S_T10    = 6'd25;
   localparam logic [5:0] S_T11    = 6'd26;
   localparam logic [5:0] S_T12    = 6'd27;
   localparam logic [5:0] S_T13    = 6'd28;
   localparam logic [5:0] S_TF     = 6'd29;
   localparam logic [5:0] S_E_INIT = 6'd30;
   localparam logic [5:0] S_E_MUL  = 6'd31;
   localparam logic [5:0] S_E_DIV  = 6'd32;
   localparam logic [5:0] S_E_WAIT = 6'd33;
   localparam logic [5:0] S_E_END  = 6'd34;
   localparam logic [5:0] S_SCALE  = 6'd35;
   localparam logic [5:0] S_FIN    = 6'd36;

   localparam logic [4:0] EXP_TERMS = 5'd24;

   logic [5:0]          state_ff, state_in;
   logic [5:0]          ret_ff, ret_in;
   logic                mode_ff, mode_in;
   logic [19:0]         step_ff, step_in;
   logic [47:0]         wl_ff, wl_in;
   logic [17:0]         ov_ff, ov_in;
   logic [31:0]         sw_ff, sw_in;
   logic [31:0]         weight_ff, weight_in;
   logic [47:0]         last_wl_ff, last_wl_in;
   logic [17:0]         first_ov_ff, first_ov_in;
   logic signed [19:0]  integ_ff, integ_in;
   logic                adj_ff, adj_in;
   logic [19:0]         fac_ff, fac_in;
   logic signed [18:0]  exp_x_ff, exp_x_in;
   logic signed [39:0]  term_ff, term_in;
   logic signed [39:0]  sum_ff, sum_in;
   logic [4:0]          n_ff, n_in;
   logic signed [58:0]  prod_ff, prod_in;
   logic                neg_ff, neg_in;
   logic [19:0]         exp_res_ff, exp_res_in;
   logic [17:0]         q_ff, q_in;
   logic signed [46:0]  sdprod_ff, sdprod_in;
   logic [40:0]         hr_ff, hr_in;
   logic [33:0]         ovr_ff, ovr_in;
   logic [16:0]         p_ff, p_in;
   logic [33:0]         pp_ff, pp_in;
   logic [17:0]         s_ff, s_in;
   logic signed [37:0]  dprod_ff, dprod_in;
   logic signed [19:0]  desired_ff, desired_in;
   logic [17:0]         scale_ff, scale_in;
   logic signed [37:0]  raw_ff, raw_in;
   logic signed [19:0]  err_ff, err_in;
   logic signed [18:0]  trend_ff, trend_in;
   logic signed [47:0]  acc_ff, acc_in;
   logic signed [13:0]  per_ff, per_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [31:0]         rsp_weight_ff, rsp_weight_in;
   logic                rsp_adj_ff, rsp_adj_in;
   pwc_div_req_type     div_req_ff, div_req_in;

   // step decay
   logic [39:0]         y_mul;
   logic [23:0]         y_rnd;
   logic [16:0]         y_cap;
   logic [19:0]         p_floor;
   logic [36:0]         pf_mul;
   logic [47:0]         delta;
   logic [47:0]         dref;
   logic [49:0]         three_ref;
   logic signed [18:0]  one_minus_q;
   logic signed [46:0]  sd_mul;
   logic [46:0]         sd_mag;
   logic [14:0]         e_mag;
   logic signed [18:0]  e_val;
   logic [19:0]         fac_sd;
   // ratio
   logic [47:0]         target;
   logic [47:0]         obase;
   logic [47:0]         ovr100, ovr105, hr100, hr105;
   logic [24:0]         ov100, stop105;
   logic [19:0]         ratio_fac;
   // trajectory
   logic [19:0]         hor;
   logic [17:0]         smooth_m;
   logic [35:0]         s_mul;
   logic signed [18:0]  d1, d2;
   logic signed [19:0]  desired_c;
   logic signed [20:0]  ov_diff;
   logic [20:0]         diff_mag;
   logic signed [37:0]  raw_c;
   logic signed [19:0]  err_c;
   logic signed [18:0]  trend_c;
   logic signed [20:0]  isum;
   logic signed [19:0]  integ_c;
   logic [63:0]         ex_full;
   logic [30:0]         ex_cap;
   logic [47:0]         ex_mul;
   logic signed [47:0]  per_r;
   logic signed [13:0]  per_c;
   logic signed [24:0]  logd_m;
   logic signed [18:0]  logd_c;
   // exp and scale
   logic [58:0]         e_pmag;
   logic signed [39:0]  e_q;
   logic signed [39:0]  e_t;
   logic [19:0]         e_res;
   logic [51:0]         w_mul;
   logic [51:0]         w_rnd;
   logic                out_free;

   assign y_mul   = 40'(step_ff) * 40'd429518;
   assign y_rnd   = 24'((y_mul + 40'd32768) >> 16);
   assign y_cap   = (y_rnd > 24'd65536) ? 17'd65536 : y_rnd[16:0];
   assign p_floor = (exp_res_ff < 20'd64225) ? 20'd64225 : exp_res_ff;
   assign pf_mul  = 37'(p_floor) * 37'd68813;
   assign delta   = wl_ff - last_wl_ff;
   assign dref    = (cfg.wl_delta_ref == 48'd0) ? 48'd1 : cfg.wl_delta_ref;
   assign three_ref   = 50'(dref) * 50'd3;
   assign one_minus_q = 19'sd65536 - $signed({1'b0, q_ff});
   assign sd_mul  = 47'(one_minus_q) * 47'sd209552160;
   assign sd_mag  = sdprod_ff[46] ? 47'(-sdprod_ff) : 47'(sdprod_ff);
   assign e_mag   = 15'((sd_mag + 47'd2147483648) >> 32);
   assign e_val   = sdprod_ff[46] ? -$signed({4'd0, e_mag}) : $signed({4'd0, e_mag});
   assign fac_sd  = (exp_res_ff < 20'd62259) ? 20'd62259 :
                    (exp_res_ff > 20'd68813) ? 20'd68813 : exp_res_ff;

   assign target  = (cfg.wl_baseline != 48'd0) ? cfg.wl_baseline :
                    (wl_ff != 48'd0) ? wl_ff : 48'd1;
   assign obase   = (cfg.ov_baseline == 18'd0) ? 48'd1 : 48'(cfg.ov_baseline);
   assign ovr100  = 48'(ovr_ff) * 48'd100;
   assign ovr105  = 48'(ovr_ff) * 48'd105;
   assign hr100   = 48'(hr_ff) * 48'd100;
   assign hr105   = 48'(hr_ff) * 48'd105;
   assign ov100   = 25'(ov_ff) * 25'd100;
   assign stop105 = 25'(cfg.stop_level) * 25'd105;

   always_comb begin
      ratio_fac = 20'd65536;
      if (ovr100 > hr105) ratio_fac = 20'd98304;
      else if (hr100 > ovr105) ratio_fac = 20'd43691;
      if ((ov100 > stop105) && (ratio_fac < 20'd81920)) ratio_fac = 20'd81920;
   end

   assign hor       = (cfg.horizon == 20'd0) ? 20'd1 : cfg.horizon;
   assign smooth_m  = 18'd196608 - {p_ff, 1'b0};
   assign s_mul     = 36'(s_ff) * 36'(smooth_m);
   assign d1        = $signed({1'b0, first_ov_ff}) - $signed({1'b0, cfg.stop_level});
   assign d2        = 19'sd65536 - $signed({1'b0, s_ff});
   assign desired_c = 20'(48'($signed({2'b0, cfg.stop_level})) + rdiv16(48'(dprod_ff)));
   assign ov_diff   = $signed({3'b0, ov_ff}) - 21'(desired_ff);
   assign diff_mag  = ov_diff[20] ? 21'(-ov_diff) : 21'(ov_diff);
   assign raw_c     = neg_ff ? -$signed(div_rsp.quo[37:0]) : $signed(div_rsp.quo[37:0]);
   assign err_c     = (raw_ff < -38'sd131072) ? -20'sd131072 :
                      (raw_ff > 38'sd262144) ? 20'sd262144 : raw_ff[19:0];
   assign trend_c   = (raw_ff < -38'sd131072) ? -19'sd131072 :
                      (raw_ff > 38'sd131072) ? 19'sd131072 : raw_ff[18:0];
   assign isum      = 21'(integ_ff) + 21'(err_c);
   assign integ_c   = (p_ff >= 17'd65536) ? 20'sd0 :
                      (isum < -21'sd196608) ? -20'sd196608 :
                      (isum > 21'sd196608) ? 20'sd196608 : isum[19:0];
   assign ex_full   = (div_rsp.quo > 64'd65536) ? div_rsp.quo - 64'd65536 : 64'd0;
   assign ex_cap    = (ex_full > 64'd1073741824) ? 31'd1073741824 : ex_full[30:0];
   assign ex_mul    = 48'(ex_cap) * 48'd655;
   assign per_r     = rdiv16(acc_ff);
   assign per_c     = (per_r < -48'sd3277) ? -14'sd3277 :
                      (per_r > 48'sd3932) ? 14'sd3932 : per_r[13:0];
   assign logd_m    = 25'(per_ff) * $signed({15'd0, cfg.interval});
   assign logd_c    = (logd_m < -25'sd65536) ? -19'sd65536 :
                      (logd_m > 25'sd81920) ? 19'sd81920 : logd_m[18:0];

   assign e_pmag    = prod_ff[58] ? 59'(-prod_ff) : 59'(prod_ff);
   assign e_q       = $signed(div_rsp.quo[39:0]);
   assign e_t       = neg_ff ? -e_q : e_q;
   assign e_res     = sum_ff[39] ? 20'd0 : 20'(($unsigned(sum_ff) + 40'd32768) >> 16);
   assign w_mul     = 52'(weight_ff) * 52'(fac_ff);
   assign w_rnd     = (w_mul + 52'd32768) >> 16;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in      = state_ff;
      ret_in        = ret_ff;
      mode_in       = mode_ff;
      step_in       = step_ff;
      wl_in         = wl_ff;
      ov_in         = ov_ff;
      sw_in         = sw_ff;
      weight_in     = weight_ff;
      last_wl_in    = last_wl_ff;
      first_ov_in   = first_ov_ff;
      integ_in      = integ_ff;
      adj_in        = adj_ff;
      fac_in        = fac_ff;
      exp_x_in      = exp_x_ff;
      term_in       = term_ff;
      sum_in        = sum_ff;
      n_in          = n_ff;
      prod_in       = prod_ff;
      neg_in        = neg_ff;
      exp_res_in    = exp_res_ff;
      q_in          = q_ff;
      sdprod_in     = sdprod_ff;
      hr_in         = hr_ff;
      ovr_in        = ovr_ff;
      p_in          = p_ff;
      pp_in         = pp_ff;
      s_in          = s_ff;
      dprod_in      = dprod_ff;
      desired_in    = desired_ff;
      scale_in      = scale_ff;
      raw_in        = raw_ff;
      err_in        = err_ff;
      trend_in      = trend_ff;
      acc_in        = acc_ff;
      per_in        = per_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_weight_in = rsp_weight_ff;
      rsp_adj_in    = rsp_adj_ff;
      div_req_in       = div_req_ff;
      div_req_in.start = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               mode_in  = req_mode;
               step_in  = req_step;
               wl_in    = req_wirelength;
               ov_in    = req_overflow;
               sw_in    = req_start_weight;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            adj_in = 1'b0;
            if (!mode_ff) begin
               weight_in   = clamp_w(52'(sw_ff), 32'(WEIGHT_MIN), cfg.weight_max);
               first_ov_in = ov_ff;
               integ_in    = '0;
               state_in    = S_FIN;
            end else if (cfg.policy == POL_STEP_DECAY) begin
               state_in = (wl_ff < last_wl_ff) ? S_SD_Y : S_SD_Q;
            end else if (cfg.interval == 10'd0) begin
               state_in = S_FIN;
            end else begin
               div_req_in.start    = 1'b1;
               div_req_in.dividend = 64'(step_ff);
               div_req_in.divisor  = 48'(cfg.interval);
               state_in            = S_MODW;
            end
         end
         S_MODW: begin
            if (div_rsp.done) begin
               if (div_rsp.rem != '0) state_in = S_FIN;
               else if (cfg.policy == POL_RATIO) state_in = S_R0;
               else state_in = S_T0;
            end
         end
         S_SD_Y: begin
            exp_x_in = -$signed({2'b0, y_cap});
            ret_in   = S_SD_P;
            state_in = S_E_INIT;
         end
         S_SD_P: begin
            fac_in   = 20'((pf_mul + 37'd32768) >> 16);
            state_in = S_SCALE;
         end
         S_SD_Q: begin
            if (50'(delta) >= three_ref) begin
               q_in     = 18'd196608;
               state_in = S_SD_E;
            end else begin
               div_req_in.start    = 1'b1;
               div_req_in.dividend = {delta, 16'd0};
               div_req_in.divisor  = dref;
               state_in            = S_SD_QW;
            end
         end
         S_SD_QW: begin
            if (div_rsp.done) begin
               q_in     = div_rsp.quo[17:0];
               state_in = S_SD_E;
            end
         end
         S_SD_E: begin
            sdprod_in = sd_mul;
            state_in  = S_SD_E2;
         end
         S_SD_E2: begin
            exp_x_in = e_val;
            ret_in   = S_SD_F;
            state_in = S_E_INIT;
         end
         S_SD_F: begin
            fac_in   = fac_sd;
            state_in = S_SCALE;
         end
         S_R0: begin
            div_req_in.start    = 1'b1;
            div_req_in.dividend = {wl_ff, 16'd0};
            div_req_in.divisor  = target;
            state_in            = S_R1;
         end
         S_R1: begin
            if (div_rsp.done) begin
               hr_in = (div_rsp.quo > 64'h100_0000_0000) ? 41'h100_0000_0000 :
                       div_rsp.quo[40:0];
               div_req_in.start    = 1'b1;
               div_req_in.dividend = 64'({ov_ff, 16'd0});
               div_req_in.divisor  = obase;
               state_in            = S_R2;
            end
         end
         S_R2: begin
            if (div_rsp.done) begin
               ovr_in   = div_rsp.quo[33:0];
               state_in = S_R3;
            end
         end
         S_R3: begin
            fac_in   = ratio_fac;
            state_in = S_SCALE;
         end
         S_T0: begin
            if (step_ff >= hor) begin
               p_in     = 17'd65536;
               state_in = S_T1;
            end else begin
               div_req_in.start    = 1'b1;
               div_req_in.dividend = 64'({step_ff, 16'd0});
               div_req_in.divisor  = 48'(hor);
               state_in            = S_TPW;
            end
         end
         S_TPW: begin
            if (div_rsp.done) begin
               p_in     = div_rsp.quo[16:0];
               state_in = S_T1;
            end
         end
         S_T1: begin
            pp_in    = 34'(p_ff) * 34'(p_ff);
            state_in = S_T2;
         end
         S_T2: begin
            s_in     = 18'((pp_ff + 34'd32768) >> 16);
            state_in = S_T3;
         end
         S_T3: begin
            s_in     = 18'((s_mul + 36'd32768) >> 16);
            state_in = S_T4;
         end
         S_T4: begin
            dprod_in = 38'(d1) * 38'(d2);
            state_in = S_T5;
         end
         S_T5: begin
            desired_in = desired_c;
            scale_in   = (cfg.stop_level > 18'd7) ? cfg.stop_level : 18'd7;
            state_in   = S_T6;
         end
         S_T6: begin
            neg_in              = ov_diff[20];
            div_req_in.start    = 1'b1;
            div_req_in.dividend = 64'({diff_mag, 16'd0}) + 64'(scale_ff >> 1);
            div_req_in.divisor  = 48'(scale_ff);
            state_in            = S_T7;
         end
         S_T7: begin
            if (div_rsp.done) begin
               raw_in   = raw_c;
               state_in = S_T8;
            end
         end
         S_T8: begin
            err_in   = err_c;
            trend_in = trend_c;
            integ_in = integ_c;
            acc_in   = 48'sd193265664 + 48'(err_c) * 48'sd5243;
            state_in = S_T9;
         end
         S_T9: begin
            acc_in   = acc_ff + 48'(integ_ff) * 48'sd197 + 48'(trend_ff) * 48'sd2621;
            state_in = S_T10;
         end
         S_T10: begin
            if ((ov_ff <= cfg.stop_level) && (cfg.wl_baseline != 48'd0)) begin
               div_req_in.start    = 1'b1;
               div_req_in.dividend = {wl_ff, 16'd0};
               div_req_in.divisor  = cfg.wl_baseline;
               state_in            = S_T11;
            end else begin
               state_in = S_T12;
            end
         end
         S_T11: begin
            if (div_rsp.done) begin
               acc_in   = acc_ff - $signed(ex_mul);
               state_in = S_T12;
            end
         end
         S_T12: begin
            per_in   = per_c;
            state_in = S_T13;
         end
         S_T13: begin
            exp_x_in = logd_c;
            ret_in   = S_TF;
            state_in = S_E_INIT;
         end
         S_TF: begin
            fac_in   = exp_res_ff;
            state_in = S_SCALE;
         end
         S_E_INIT: begin
            term_in  = 40'sd4294967296;
            sum_in   = 40'sd4294967296;
            n_in     = 5'd1;
            state_in = S_E_MUL;
         end
         S_E_MUL: begin
            prod_in  = 59'(term_ff) * 59'(exp_x_ff);
            state_in = S_E_DIV;
         end
         S_E_DIV: begin
            neg_in              = prod_ff[58];
            div_req_in.start    = 1'b1;
            div_req_in.dividend = 64'(e_pmag[58:16]);
            div_req_in.divisor  = 48'(n_ff);
            state_in            = S_E_WAIT;
         end
         S_E_WAIT: begin
            if (div_rsp.done) begin
               term_in = e_t;
               sum_in  = sum_ff + e_t;
               if (n_ff == EXP_TERMS) begin
                  state_in = S_E_END;
               end else begin
                  n_in     = n_ff + 5'd1;
                  state_in = S_E_MUL;
               end
            end
         end
         S_E_END: begin
            exp_res_in = e_res;
            state_in   = ret_ff;
         end
         S_SCALE: begin
            weight_in = clamp_w(w_rnd, 32'(WEIGHT_MIN), cfg.weight_max);
            adj_in    = 1'b1;
            state_in  = S_FIN;
         end
         S_FIN: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_weight_in = weight_ff;
               rsp_adj_in    = adj_ff;
               last_wl_in    = wl_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         weight_ff        <= '0;
         last_wl_ff       <= '0;
         first_ov_ff      <= '0;
         integ_ff         <= '0;
         rsp_valid_ff     <= 1'b0;
         div_req_ff.start <= 1'b0;
      end else begin
         state_ff         <= state_in;
         weight_ff        <= weight_in;
         last_wl_ff       <= last_wl_in;
         first_ov_ff      <= first_ov_in;
         integ_ff         <= integ_in;
         rsp_valid_ff     <= rsp_valid_in;
         div_req_ff.start <= div_req_in.start;
      end
      div_req_ff.dividend <= div_req_in.dividend;
      div_req_ff.divisor  <= div_req_in.divisor;
      ret_ff        <= ret_in;
      mode_ff       <= mode_in;
      step_ff       <= step_in;
      wl_ff         <= wl_in;
      ov_ff         <= ov_in;
      sw_ff         <= sw_in;
      adj_ff        <= adj_in;
      fac_ff        <= fac_in;
      exp_x_ff      <= exp_x_in;
      term_ff       <= term_in;
      sum_ff        <= sum_in;
      n_ff          <= n_in;
      prod_ff       <= prod_in;
      neg_ff        <= neg_in;
      exp_res_ff    <= exp_res_in;
      q_ff          <= q_in;
      sdprod_ff     <= sdprod_in;
      hr_ff         <= hr_in;
      ovr_ff        <= ovr_in;
      p_ff          <= p_in;
      pp_ff         <= pp_in;
      s_ff          <= s_in;
      dprod_ff      <= dprod_in;
      desired_ff    <= desired_in;
      scale_ff      <= scale_in;
      raw_ff        <= raw_in;
      err_ff        <= err_in;
      trend_ff      <= trend_in;
      acc_ff        <= acc_in;
      per_ff        <= per_in;
      rsp_weight_ff <= rsp_weight_in;
      rsp_adj_ff    <= rsp_adj_in;
   end

   assign req_stall    = (state_ff != S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_weight   = rsp_weight_ff;
   assign rsp_adjusted = rsp_adj_ff;
   assign div_req      = div_req_ff;

endmodule

### rtl/penalty_weight_controller_top.sv
`timescale 1ns / 1ps
// Penalty weight controller top: configuration registers, sequencer core, shared divider.
// Initialize uses no divide; a skipped update at most one; a ratio update three. The
// step-decay and trajectory updates evaluate a 24-term exp, one divide per term through
// the shared divider, plus the other divides of their policy.
// One request in flight; the next is taken once the result registers, even if it waits.
// Synchronous active-high reset clears control state and the weight, and sets the configuration to its defaults.
module penalty_weight_controller_top import pwc_pkg::*; #(
   parameter int WEIGHT_MIN = WEIGHT_MIN_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [19:0] req_step,
   input  logic [47:0] req_wirelength,
   input  logic [17:0] req_overflow,
   input  logic [31:0] req_start_weight,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_weight,
   output logic        rsp_adjusted,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [47:0] csr_data
);
   pwc_cfg_type     cfg_ff, cfg_in;
   pwc_div_req_type div_req;
   pwc_div_rsp_type div_rsp;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_POLICY:     cfg_in.policy       = csr_data[1:0];
            CSR_WEIGHT_MAX: cfg_in.weight_max   = csr_data[31:0];
            CSR_WL_DELTA:   cfg_in.wl_delta_ref = csr_data;
            CSR_INTERVAL:   cfg_in.interval     = csr_data[9:0];
            CSR_HORIZON:    cfg_in.horizon      = csr_data[19:0];
            CSR_STOP_LEVEL: cfg_in.stop_level   = csr_data[17:0];
            CSR_WL_BASE:    cfg_in.wl_baseline  = csr_data;
            CSR_OV_BASE:    cfg_in.ov_baseline  = csr_data[17:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.policy       <= POL_STEP_DECAY;
         cfg_ff.weight_max   <= 32'hFFFF_FFFF;
         cfg_ff.wl_delta_ref <= 48'd1;
         cfg_ff.interval     <= '0;
         cfg_ff.horizon      <= 20'd1;
         cfg_ff.stop_level   <= '0;
         cfg_ff.wl_baseline  <= '0;
         cfg_ff.ov_baseline  <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pwc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   pwc_core #(
      .WEIGHT_MIN (WEIGHT_MIN)
   ) u_core (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_step         (req_step),
      .req_wirelength   (req_wirelength),
      .req_overflow     (req_overflow),
      .req_start_weight (req_start_weight),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_weight       (rsp_weight),
      .rsp_adjusted     (rsp_adjusted),
      .div_req          (div_req),
      .div_rsp          (div_rsp)
   );

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// Testbench for penalty_weight_controller_top: random and directed requests
// across register settings, checked against a weight predictor class.
// Depends on pwc_pkg for register index and policy codes.
module tb;
   import pwc_pkg::*;

   typedef struct {
      logic [31:0] weight;
      logic        adjusted;
   } weight_result_t;

   class weight_predictor;
      longint unsigned policy, wmax, dref, intv, hor, stop, wlb, ovb;
      longint unsigned weight, last_wl, last_ov, first_ov;
      longint          integ;
      weight_result_t  pending[$];

      function new();
         policy = 0; wmax = 64'hFFFF_FFFF; dref = 1; intv = 0; hor = 1;
         stop = 0; wlb = 0; ovb = 0;
         weight = 0; last_wl = 0; last_ov = 0; first_ov = 0; integ = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [47:0] v);
         case (idx)
            CSR_POLICY:     policy = v[1:0];
            CSR_WEIGHT_MAX: wmax = v[31:0];
            CSR_WL_DELTA:   dref = v;
            CSR_INTERVAL:   intv = v[9:0];
            CSR_HORIZON:    hor = v[19:0];
            CSR_STOP_LEVEL: stop = v[17:0];
            CSR_WL_BASE:    wlb = v;
            CSR_OV_BASE:    ovb = v[17:0];
            default: ;
         endcase
      endfunction

      function longint rnd_div(longint v, longint d);
         if (v >= 0) return (v + d / 2) / d;
         return -((-v + d / 2) / d);
      endfunction

      function longint clip(longint v, longint lo, longint hi);
         return v < lo ? lo : (v > hi ? hi : v);
      endfunction

      function longint unsigned exp16(longint x);
         longint term, sum;
         term = 64'sd4294967296;
         sum = term;
         x = clip(x, -131072, 131072);
         for (int n = 1; n <= 24; n++) begin
            term = term * x / 65536 / n;
            sum += term;
         end
         if (sum < 0) return 0;
         return (longint'(sum) + 32768) / 65536;
      endfunction

      function void apply_factor(longint unsigned f);
         longint unsigned v;
         v = (weight * f + 32768) >> 16;
         if (v < 66) v = 66;
         if (v > wmax) v = wmax;
         weight = v;
      endfunction

      function void decay(longint unsigned st, longint unsigned wl);
         longint unsigned y, p, f, delta, r, q;
         longint e;
         if (wl < last_wl) begin
            y = (st * 429518 + 32768) >> 16;
            if (y > 65536) y = 65536;
            p = exp16(-longint'(y));
            if (p < 64225) p = 64225;
            f = (p * 68813 + 32768) >> 16;
         end else begin
            delta = wl - last_wl;
            r = dref ? dref : 1;
            if (delta >= 3 * r) q = 3 * 65536;
            else q = (delta / r) * 65536 + ((delta % r) << 16) / r;
            e = rnd_div((65536 - longint'(q)) * 209552160, 64'sd4294967296);
            f = exp16(e);
            if (f < 62259) f = 62259;
            if (f > 68813) f = 68813;
         end
         apply_factor(f);
      endfunction

      function void balance(longint unsigned wl, longint unsigned ov);
         longint unsigned tgt, ob, hr, ovr, f;
         tgt = wlb ? wlb : wl;
         ob = ovb ? ovb : 1;
         f = 65536;
         if (tgt == 0) tgt = 1;
         hr = (wl << 16) / tgt;
         if (hr > (64'd1 << 40)) hr = 64'd1 << 40;
         ovr = (ov << 16) / ob;
         if (ovr * 100 > hr * 105) f = 98304;
         else if (hr * 100 > ovr * 105) f = 43691;
         if (ov * 100 > stop * 105 && f < 81920) f = 81920;
         apply_factor(f);
      endfunction

      function void trajectory(longint unsigned st, longint unsigned wl, longint unsigned ov);
         longint unsigned h, rr, ex;
         longint p, s, desired, scl, raw, err, trend, acc, per, logd, sl;
         h = hor ? hor : 1;
         sl = longint'(stop);
         p = st >= h ? 65536 : longint'((st << 16) / h);
         s = (p * p + 32768) / 65536;
         s = (s * (3 * 65536 - 2 * p) + 32768) / 65536;
         desired = sl + rnd_div((longint'(first_ov) - sl) * (65536 - s), 65536);
         scl = sl > 7 ? sl : 7;
         raw = rnd_div((longint'(ov) - desired) * 65536, scl);
         err = clip(raw, -131072, 262144);
         trend = clip(raw, -131072, 131072);
         if (p < 65536) integ = clip(integ + err, -196608, 196608);
         else integ = 0;
         acc = 2949 * 65536 + 5243 * err + 197 * integ + 2621 * trend;
         if (ov <= stop && wlb > 0) begin
            rr = (wl << 16) / wlb;
            ex = rr > 65536 ? rr - 65536 : 0;
            if (ex > (64'd1 << 30)) ex = 64'd1 << 30;
            acc -= 655 * longint'(ex);
         end
         per = clip(rnd_div(acc, 65536), -3277, 3932);
         logd = clip(per * longint'(intv), -65536, 81920);
         apply_factor(exp16(logd));
      endfunction

      function void note_request(logic md, logic [19:0] st, logic [47:0] wl,
                                 logic [17:0] ov, logic [31:0] sw);
         weight_result_t r;
         r.adjusted = 0;
         if (!md) begin
            weight = sw;
            if (weight < 66) weight = 66;
            if (weight > wmax) weight = wmax;
            last_wl = wl; last_ov = ov; first_ov = ov; integ = 0;
         end else begin
            if (policy == 0) begin
               decay(st, wl);
               r.adjusted = 1;
            end else if (intv > 0 && (st % intv) == 0) begin
               if (policy == 2) balance(wl, ov);
               else trajectory(st, wl, ov);
               last_ov = ov;
               r.adjusted = 1;
            end
            last_wl = wl;
         end
         r.weight = weight[31:0];
         pending.push_back(r);
      endfunction

      function string check_response(logic [31:0] w, logic a);
         weight_result_t e;
         if (pending.size() == 0) return $sformatf("unexpected response weight %h", w);
         e = pending.pop_front();
         if (w !== e.weight || a !== e.adjusted)
            return $sformatf("weight %h adjusted %b, expected %h %b", w, a, e.weight,
                             e.adjusted);
         return "";
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0, req_mode = 0;
   logic [19:0] req_step = 0;
   logic [47:0] req_wirelength = 0;
   logic [17:0] req_overflow = 0;
   logic [31:0] req_start_weight = 0;
   logic        rsp_stall = 0;
   logic        csr_valid = 0;
   logic [2:0]  csr_index = 0;
   logic [47:0] csr_data = 0;
   logic        req_stall, rsp_valid, rsp_adjusted, csr_ready;
   logic [31:0] rsp_weight;

   weight_predictor pred = new();
   int          errors = 0;
   int          sent = 0;
   bit          quiet = 0;
   int          idle_cycles = 0;
   int          stall_left = 0;
   logic [19:0] cur_step;
   logic [47:0] cur_wl;
   logic [17:0] cur_ov;

   penalty_weight_controller_top uut (.*);

   always #5 clock = ~clock;

   task automatic report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
   endtask

   always @(posedge clock) begin
      string m;
      if (!reset && rsp_valid && !rsp_stall) begin
         m = pred.check_response(rsp_weight, rsp_adjusted);
         if (m != "") report(m);
      end
   end

   always @(negedge clock) begin
      if (stall_left > 0) stall_left--;
      else if (!quiet && !reset && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 14);
      rsp_stall = stall_left > 0;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles > 20000) begin
         $display("penalty_weight_controller_top verification failed");
         $finish;
      end
   end

   function automatic logic [47:0] rand48();
      return 48'({$urandom, $urandom});
   endfunction

   task automatic write_reg(logic [2:0] idx, logic [47:0] v);
      @(negedge clock);
      csr_valid = 1; csr_index = idx; csr_data = v;
      do @(posedge clock); while (!csr_ready);
      pred.write_reg(idx, v);
      @(negedge clock);
      csr_valid = 0;
   endtask

   task automatic configure(logic [47:0] pol, logic [47:0] wmax, logic [47:0] dref,
                            logic [47:0] intv, logic [47:0] hor, logic [47:0] stop,
                            logic [47:0] wlb, logic [47:0] ovb);
      write_reg(CSR_POLICY, pol);
      write_reg(CSR_WEIGHT_MAX, wmax);
      write_reg(CSR_WL_DELTA, dref);
      write_reg(CSR_INTERVAL, intv);
      write_reg(CSR_HORIZON, hor);
      write_reg(CSR_STOP_LEVEL, stop);
      write_reg(CSR_WL_BASE, wlb);
      write_reg(CSR_OV_BASE, ovb);
   endtask

   // hold until every response has come, then let the block settle
   task automatic drain();
      while (pred.pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic send(logic md, logic [19:0] st, logic [47:0] wl, logic [17:0] ov,
                       logic [31:0] sw);
      int gap;
      gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
      if (gap > 0) begin
         req_valid = 0;
         repeat (gap) @(negedge clock);
      end
      req_mode = md; req_step = st; req_wirelength = wl; req_overflow = ov;
      req_start_weight = sw; req_valid = 1;
      do @(posedge clock); while (req_stall);
      pred.note_request(md, st, wl, ov, sw);
      sent++;
      cur_step = st; cur_wl = wl; cur_ov = ov;
      @(negedge clock);
   endtask

   task automatic random_phase(int count);
      logic [47:0] d, lim;
      logic [19:0] st;
      logic [47:0] wl;
      logic [17:0] ov;
      send(0, 0, rand48() >> $urandom_range(0, 40), 18'($urandom), $urandom);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < 5) begin
            send($urandom_range(0, 4) != 0, 20'($urandom), rand48(), 18'($urandom),
                 $urandom);
         end else if ($urandom_range(0, 99) < 3) begin
            send(0, cur_step, cur_wl, cur_ov, $urandom);
         end else begin
            lim = (pred.dref > 48'h3FFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF :
                  48'(4 * pred.dref + 1);
            d = rand48() % lim;
            st = cur_step + 20'd1;
            wl = ($urandom_range(0, 2) == 0) ? cur_wl - d : cur_wl + d;
            ov = ($urandom_range(0, 9) == 0) ? 18'($urandom) :
                 cur_ov - 18'($urandom_range(0, 300)) + 18'($urandom_range(0, 100));
            send(1, st, wl, ov, $urandom);
         end
      end
      req_valid = 0;
   endtask

   initial begin
      logic [47:0] p, wm, dr, iv, hz, sl, wb, ob;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // reset defaults: step-decay policy
      send(0, 0, 1000, 18'h3FFFF, 0);
      send(1, 0, 500, 0, 32'hFFFF_FFFF);
      send(1, 20'hFFFFF, 100, 18'h3FFFF, 0);
      send(1, 5, 100, 0, 0);
      send(1, 6, 48'hFFFF_FFFF_FFFF, 0, 0);
      send(0, 0, 0, 0, 32'hFFFF_FFFF);
      send(1, 1, 0, 0, 0);
      req_valid = 0;
      drain();

      // weight_max below the floor, zero delta ref and horizon, ratio policy
      configure(POL_RATIO, 50, 0, 1, 0, 0, 0, 0);
      send(0, 0, 0, 0, 1000);
      send(1, 1, 0, 0, 0);
      send(1, 2, 48'hFFFF_FFFF_FFFF, 18'h3FFFF, 0);
      req_valid = 0;
      drain();

      configure(POL_TRAJECTORY, 32'hFFFF_FFFF, 1000, 4, 100, 655, 10000, 6553);
      send(0, 0, 5000, 60000, 32'h0001_0000);
      send(1, 4, 20000, 50000, 0);
      send(1, 5, 20000, 0, 0);
      send(1, 8, 4000, 0, 0);
      send(1, 100, 48'hFFFF_FFFF_FFFF, 0, 0);
      send(1, 200, 100, 18'h3FFFF, 0);
      req_valid = 0;
      drain();

      // policy code 3 acts as the trajectory policy
      configure(3, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1023, 20'hFFFFF, 18'h3FFFF,
                48'hFFFF_FFFF_FFFF, 18'h3FFFF);
      send(0, 0, 1, 18'h3FFFF, 32'h8000_0000);
      send(1, 0, 2, 0, 0);
      send(1, 1023, 3, 18'h3FFFF, 0);
      send(1, 1, 4, 0, 0);
      req_valid = 0;
      drain();

      configure(POL_RATIO, 32'hFFFF_FFFF, 1, 0, 1, 0, 0, 0);
      send(1, 0, 7, 7, 0);
      req_valid = 0;
      drain();

      while (sent < 2000) begin
         if (sent > 1800) quiet = 1;
         p = $urandom_range(0, 3);
         case ($urandom_range(0, 7))
            0: wm = $urandom_range(0, 100);
            1: wm = 32'hFFFF_FFFF;
            default: wm = $urandom;
         endcase
         dr = ($urandom_range(0, 7) == 0) ? rand48() : 48'($urandom_range(0, 1 << 20));
         case ($urandom_range(0, 9))
            0: iv = 0;
            1: iv = 1023;
            2: iv = $urandom_range(0, 1023);
            default: iv = $urandom_range(1, 8);
         endcase
         case ($urandom_range(0, 9))
            0: hz = 0;
            1: hz = 20'hFFFFF;
            default: hz = $urandom_range(1, 500);
         endcase
         sl = ($urandom_range(0, 3) == 0) ? 48'($urandom) : 48'($urandom_range(0, 8000));
         wb = ($urandom_range(0, 2) == 0) ? 48'd0 : rand48() >> $urandom_range(0, 40);
         ob = ($urandom_range(0, 3) == 0) ? 48'd0 : 48'($urandom);
         // now and then set the unused upper data bits as well
         if ($urandom_range(0, 3) == 0) begin
            p |= rand48() << 2; wm |= rand48() << 32; iv |= rand48() << 10;
            hz |= rand48() << 20; sl |= rand48() << 18; ob |= rand48() << 18;
         end
         configure(p, wm, dr, iv, hz, sl, wb, ob);
         random_phase($urandom_range(30, 100));
         drain();
      end

      while (pred.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (errors == 0)
         $display("penalty_weight_controller_top verification clean");
      else
         $display("penalty_weight_controller_top verification failed");
      $finish;
   end

endmodule

### sim.f
rtl/pwc_pkg.sv
rtl/pwc_div.sv
rtl/pwc_core.sv
rtl/penalty_weight_controller_top.sv
verif/tb.sv
